>>> rtl/core/ialk_pkg.sv
// Shared types and constants of the intruder alarm keypad controller.
// Holds the configuration and result structs, mode and key codes and register indexes.
// No dependencies.
`default_nettype none

package ialk_pkg;

    // Panel modes
    localparam logic [2:0] MODE_UNSET  = 3'd0;
    localparam logic [2:0] MODE_EXIT   = 3'd1;
    localparam logic [2:0] MODE_ALARM  = 3'd2;
    localparam logic [2:0] MODE_SET    = 3'd3;
    localparam logic [2:0] MODE_ENTRY  = 3'd4;
    localparam logic [2:0] MODE_REPORT = 3'd5;

    // Key codes above the digits
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_ENTER      = 4'd10;
    localparam logic [3:0] KEY_DELETE     = 4'd11;
    localparam logic [3:0] DIGIT_EMPTY    = 4'd15;

    // LED bits
    localparam int LED_ALARM  = 0;
    localparam int LED_DOOR   = 1;
    localparam int LED_SENSOR = 2;

    // Configuration register indexes
    localparam int          CFG_IDX_W         = 3;
    localparam logic [2:0]  REG_CODE_DIGITS   = 3'd0;
    localparam logic [2:0]  REG_EXIT_DELAY    = 3'd1;
    localparam logic [2:0]  REG_ENTRY_DELAY   = 3'd2;
    localparam logic [2:0]  REG_ALARM_LED     = 3'd3;
    localparam logic [2:0]  REG_FLASH_HALF    = 3'd4;
    localparam logic [2:0]  REG_WRONG_LIMIT   = 3'd5;
    localparam int          CFG_DATA_W        = 16;

    // Reset values of the registers
    localparam logic [15:0] RST_CODE_DIGITS = 16'h2468;
    localparam logic [15:0] RST_EXIT_DELAY  = 16'd1000;
    localparam logic [15:0] RST_ENTRY_DELAY = 16'd1000;
    localparam logic [15:0] RST_ALARM_LED   = 16'd12000;
    localparam logic [15:0] RST_FLASH_HALF  = 16'd50;
    localparam logic [3:0]  RST_WRONG_LIMIT = 4'd3;

    // Default parameter values
    localparam int DEF_CODE_LENGTH = 4;
    localparam int DEF_TIMER_BITS  = 16;

    // Stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic [15:0] code_digits;
        logic [15:0] exit_delay_ticks;
        logic [15:0] entry_delay_ticks;
        logic [15:0] alarm_led_ticks;
        logic [15:0] flash_half_ticks;
        logic [3:0]  wrong_code_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  panel_state;
        logic        alarm_led;
        logic        door_led;
        logic        sensor_led;
        logic [2:0]  entered_count;
        logic [15:0] entered_digits;
        logic [3:0]  wrong_count;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/ialk_cfg.sv
// Configuration register file of the alarm controller.
// Takes one write transfer per cycle; depends on ialk_pkg.
`default_nettype none

module ialk_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ialk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ialk_pkg::CFG_DATA_W-1:0] cfg_data,
    output ialk_pkg::cfg_t                       cfg
);
    import ialk_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_CODE_DIGITS: cfg_next.code_digits       = cfg_data;
                REG_EXIT_DELAY:  cfg_next.exit_delay_ticks  = cfg_data;
                REG_ENTRY_DELAY: cfg_next.entry_delay_ticks = cfg_data;
                REG_ALARM_LED:   cfg_next.alarm_led_ticks   = cfg_data;
                REG_FLASH_HALF:  cfg_next.flash_half_ticks  = cfg_data;
                REG_WRONG_LIMIT: cfg_next.wrong_code_limit  = cfg_data[3:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_digits       <= RST_CODE_DIGITS;
            cfg_reg.exit_delay_ticks  <= RST_EXIT_DELAY;
            cfg_reg.entry_delay_ticks <= RST_ENTRY_DELAY;
            cfg_reg.alarm_led_ticks   <= RST_ALARM_LED;
            cfg_reg.flash_half_ticks  <= RST_FLASH_HALF;
            cfg_reg.wrong_code_limit  <= RST_WRONG_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ialk_fsm.sv
// Panel state machine: mode, digit buffer, wrong-code count, timers and LEDs.
// Updates once per accepted poll tick; depends on ialk_pkg.
`default_nettype none

module ialk_fsm #(
    parameter int CODE_LENGTH = ialk_pkg::DEF_CODE_LENGTH,
    parameter int TIMER_BITS  = ialk_pkg::DEF_TIMER_BITS
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            tick,
    input  wire logic            key_valid,
    input  wire logic [3:0]      key_code,
    input  wire logic            door_open,
    input  wire logic            motion_detected,
    input  wire ialk_pkg::cfg_t  cfg,
    output ialk_pkg::result_t    result
);
    import ialk_pkg::*;

    localparam int CNT_W = $clog2(CODE_LENGTH + 1);

    typedef struct packed {
        logic [2:0]            mode;
        logic [TIMER_BITS-1:0] dly;
        logic [TIMER_BITS-1:0] fl;
        logic [TIMER_BITS-1:0] alt;
        logic [2:0]            leds;
    } ctl_t;

    ctl_t             ctl_reg, ctl_next;
    logic [3:0]       dig_reg  [CODE_LENGTH];
    logic [3:0]       dig_next [CODE_LENGTH];
    logic [CNT_W-1:0] tot_reg, tot_next;
    logic [3:0]       tries_reg, tries_next;
    logic [4*CODE_LENGTH-1:0] packed_digits;

    // Mode change with its entry actions; no change when already in that mode
    function automatic ctl_t go_mode(input ctl_t s, input logic [2:0] nxt, input cfg_t c);
        ctl_t r;
        r = s;
        if (nxt != s.mode) begin
            if (s.mode == MODE_ALARM) begin
                r.alt = '0;
            end
            r.mode = nxt;
            r.dly  = '0;
            r.fl   = '0;
            case (nxt)
                MODE_UNSET: begin
                    r.leds = '0;
                    r.alt  = '0;
                end
                MODE_EXIT:   r.dly = TIMER_BITS'(c.exit_delay_ticks);
                MODE_ENTRY:  r.dly = TIMER_BITS'(c.entry_delay_ticks);
                MODE_ALARM: begin
                    r.leds[LED_ALARM] = 1'b1;
                    r.alt = TIMER_BITS'(c.alarm_led_ticks);
                end
                MODE_REPORT: r.leds[LED_ALARM] = 1'b0;
                default: ;
            endcase
        end
        return r;
    endfunction

    always_comb begin
        logic [2:0] m0;
        logic       match;
        logic [3:0] want;
        logic [3:0] limit;

        ctl_next   = ctl_reg;
        dig_next   = dig_reg;
        tot_next   = tot_reg;
        tries_next = tries_reg;
        m0         = ctl_reg.mode;
        match      = 1'b0;
        want       = '0;
        limit      = cfg.wrong_code_limit;

        if (tick) begin
            // Flash runs first in the delay modes
            if (m0 == MODE_EXIT || m0 == MODE_ENTRY) begin
                if (ctl_next.fl == '0) begin
                    ctl_next.leds[LED_ALARM] = ~ctl_next.leds[LED_ALARM];
                    ctl_next.fl = (cfg.flash_half_ticks == '0) ? '0
                                : TIMER_BITS'(cfg.flash_half_ticks - 16'd1);
                end else begin
                    ctl_next.fl = ctl_next.fl - 1'b1;
                end
            end

            // Keypad
            if (key_valid && (m0 == MODE_UNSET || m0 == MODE_EXIT ||
                              m0 == MODE_ALARM || m0 == MODE_ENTRY) &&
                key_code <= KEY_DELETE) begin
                if (key_code <= KEY_LAST_DIGIT) begin
                    if (tot_reg < CNT_W'(CODE_LENGTH)) begin
                        for (int i = 0; i < CODE_LENGTH; i++) begin
                            if (CNT_W'(i) == tot_reg) begin
                                dig_next[i] = key_code;
                            end
                        end
                        tot_next = tot_reg + 1'b1;
                    end
                end else if (key_code == KEY_DELETE) begin
                    if (tot_reg != '0) begin
                        tot_next = tot_reg - 1'b1;
                        for (int i = 0; i < CODE_LENGTH; i++) begin
                            if (CNT_W'(i) == tot_next) begin
                                dig_next[i] = DIGIT_EMPTY;
                            end
                        end
                    end
                end else begin
                    match = (tot_reg == CNT_W'(CODE_LENGTH));
                    for (int i = 0; i < CODE_LENGTH; i++) begin
                        want = 4'((cfg.code_digits >> (4 * (CODE_LENGTH - 1 - i))) & 16'hF);
                        if (dig_reg[i] != want) begin
                            match = 1'b0;
                        end
                    end
                    if (match) begin
                        tries_next = '0;
                        if (ctl_next.mode == MODE_UNSET) begin
                            ctl_next = go_mode(ctl_next, MODE_EXIT, cfg);
                        end else if (ctl_next.mode == MODE_EXIT ||
                                     ctl_next.mode == MODE_ENTRY) begin
                            ctl_next = go_mode(ctl_next, MODE_UNSET, cfg);
                        end else if (ctl_next.mode == MODE_ALARM) begin
                            ctl_next = go_mode(ctl_next, MODE_REPORT, cfg);
                        end
                    end else begin
                        if (tries_reg != 4'd15) begin
                            tries_next = tries_reg + 1'b1;
                        end
                        if (ctl_next.mode == MODE_ENTRY) begin
                            ctl_next = go_mode(ctl_next, MODE_ALARM, cfg);
                        end
                    end
                    for (int i = 0; i < CODE_LENGTH; i++) begin
                        dig_next[i] = DIGIT_EMPTY;
                    end
                    tot_next = '0;
                end
                if ((ctl_next.mode == MODE_UNSET || ctl_next.mode == MODE_EXIT) &&
                    tries_next != '0 && tries_next >= limit) begin
                    ctl_next = go_mode(ctl_next, MODE_ALARM, cfg);
                end
            end

            case (m0)
                MODE_EXIT, MODE_ENTRY: begin
                    if (motion_detected) begin
                        ctl_next.leds[LED_SENSOR] = 1'b1;
                        ctl_next = go_mode(ctl_next, MODE_ALARM, cfg);
                    end
                    if (ctl_next.mode == m0) begin
                        if (ctl_next.dly <= TIMER_BITS'(1)) begin
                            ctl_next = go_mode(ctl_next,
                                (m0 == MODE_EXIT) ? MODE_SET : MODE_ALARM, cfg);
                        end else begin
                            ctl_next.dly = ctl_next.dly - 1'b1;
                        end
                    end
                end
                MODE_SET: begin
                    if (door_open) begin
                        ctl_next.leds[LED_DOOR] = 1'b1;
                        ctl_next = go_mode(ctl_next, MODE_ENTRY, cfg);
                    end
                    if (motion_detected) begin
                        ctl_next.leds[LED_SENSOR] = 1'b1;
                        ctl_next = go_mode(ctl_next, MODE_ALARM, cfg);
                    end
                end
                MODE_ALARM: begin
                    // Alarm LED hold time
                    if (ctl_next.mode == MODE_ALARM && ctl_next.alt != '0) begin
                        if (ctl_next.alt <= TIMER_BITS'(1)) begin
                            ctl_next.alt = '0;
                            ctl_next.leds[LED_ALARM] = 1'b0;
                        end else begin
                            ctl_next.alt = ctl_next.alt - 1'b1;
                        end
                    end
                end
                MODE_REPORT: begin
                    if (key_valid && key_code == KEY_DELETE) begin
                        ctl_next = go_mode(ctl_next, MODE_UNSET, cfg);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg   <= '0;
            tot_reg   <= '0;
            tries_reg <= '0;
            for (int i = 0; i < CODE_LENGTH; i++) begin
                dig_reg[i] <= DIGIT_EMPTY;
            end
        end else begin
            ctl_reg   <= ctl_next;
            tot_reg   <= tot_next;
            tries_reg <= tries_next;
            dig_reg   <= dig_next;
        end
    end

    // First digit in the top nibble
    always_comb begin
        for (int i = 0; i < CODE_LENGTH; i++) begin
            packed_digits[4*(CODE_LENGTH-1-i) +: 4] = dig_reg[i];
        end
    end

    assign result.panel_state    = ctl_reg.mode;
    assign result.alarm_led      = ctl_reg.leds[LED_ALARM];
    assign result.door_led       = ctl_reg.leds[LED_DOOR];
    assign result.sensor_led     = ctl_reg.leds[LED_SENSOR];
    assign result.entered_count  = 3'(tot_reg);
    assign result.entered_digits = 16'(packed_digits);
    assign result.wrong_count    = tries_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tot_reg <= CNT_W'(CODE_LENGTH))
        else $error("digit count beyond code length");

    a_delay_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl_reg.mode == MODE_EXIT || ctl_reg.mode == MODE_ENTRY) |->
            (ctl_reg.dly == '0 && ctl_reg.fl == '0))
        else $error("delay or flash timer running outside a delay mode");

    a_alarm_timer_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.mode != MODE_ALARM |-> ctl_reg.alt == '0)
        else $error("alarm LED timer left running outside alarm");

    a_report_clears_tries: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick && ctl_reg.mode == MODE_ALARM && ctl_next.mode == MODE_REPORT) |=>
            tries_reg == '0)
        else $error("report reached without clearing wrong-code count");

    a_unset_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick && ctl_reg.mode != MODE_UNSET && ctl_next.mode == MODE_UNSET) |=>
            ctl_reg.leds == '0)
        else $error("LEDs left lit on return to unset");
`endif

endmodule

`default_nettype wire

>>> rtl/core/intruder_alarm_keypad_controller.sv
// Top level of the intruder alarm keypad controller: stream handshake and result register.
// Instantiates ialk_cfg and ialk_fsm; depends on ialk_pkg.
//
//  channel   dir  payload                                          transfer when
//  s_*       in   poll tick: key, door and motion levels            s_tvalid & s_tready
//  m_*       out  panel state, LEDs, digit buffer, wrong count      m_tvalid & m_tready
//  cfg_*     in   register index and write data                    cfg_valid & cfg_ready
//
// The state registers take each poll tick's update at the end of its transfer cycle
// and hold the result until it is taken. A new tick is accepted every cycle
// while the result register is empty or being read. A stalled m_tready stalls s_tready.
// aresetn is synchronous; it restores the register defaults and the unset mode.
// Configuration writes are taken in every cycle.
`default_nettype none

module intruder_alarm_keypad_controller #(
    parameter int CODE_LENGTH = ialk_pkg::DEF_CODE_LENGTH,
    parameter int TIMER_BITS  = ialk_pkg::DEF_TIMER_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // tdata: key_valid[0], key_code[4:1], door_open[5], motion_detected[6], zero[7]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ialk_pkg::S_TDATA_W-1:0]  s_tdata,
    // tdata: panel_state[2:0], alarm_led[3], door_led[4], sensor_led[5],
    //        entered_count[8:6], entered_digits[24:9], wrong_count[28:25], zero[31:29]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ialk_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ialk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ialk_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ialk_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    m_valid_reg, m_valid_next;
    logic    accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    ialk_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ialk_fsm #(
        .CODE_LENGTH (CODE_LENGTH),
        .TIMER_BITS  (TIMER_BITS)
    ) u_fsm (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tick            (accept),
        .key_valid       (s_tdata[0]),
        .key_code        (s_tdata[4:1]),
        .door_open       (s_tdata[5]),
        .motion_detected (s_tdata[6]),
        .cfg             (cfg),
        .result          (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, result.wrong_count, result.entered_digits,
                       result.entered_count, result.sensor_led, result.door_led,
                       result.alarm_led, result.panel_state};

endmodule

`default_nettype wire
